// ----- design/rycc_pkg.sv -----
package rycc_pkg;

  localparam int CFG_PAIRS_W = 11;
  localparam int CFG_ROWS_W  = 12;
  localparam int CFG_DATA_W  = 12;
  localparam int PIX_W       = 8;

  localparam logic [CFG_PAIRS_W-1:0] PAIRS_RESET = 11'd320;
  localparam logic [CFG_ROWS_W-1:0]  ROWS_RESET  = 12'd480;

  // register indexes on the configuration port
  localparam logic REG_PAIRS_PER_ROW = 1'b0;
  localparam logic REG_FRAME_ROWS    = 1'b1;

  localparam logic [PIX_W-1:0] CHROMA_BIAS = 8'd32;

  typedef struct packed {
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] c1;
    logic [PIX_W-1:0] c2;
  } lane_out_t;

  typedef struct packed {
    logic odd_row;
    logic last_row;
    logic frame_end;
  } ctrl_t;

endpackage

// ----- design/rycc_lane.sv -----
module rycc_lane (
  input  logic                        clk,
  input  logic                        en,
  input  logic [rycc_pkg::PIX_W-1:0]  red,
  input  logic [rycc_pkg::PIX_W-1:0]  green,
  input  logic [rycc_pkg::PIX_W-1:0]  blue,
  output rycc_pkg::lane_out_t         res_r
);
  import rycc_pkg::*;

  logic        [17:0] y_sum;
  logic signed [18:0] r_s, g_s, b_s;
  logic signed [18:0] t1, t2;
  logic signed [18:0] q1, q2;
  lane_out_t          res_nxt;

  always_comb begin
    y_sum = 18'd306 * {10'd0, red} + 18'd601 * {10'd0, green} + 18'd117 * {10'd0, blue};
    r_s = signed'({11'd0, red});
    g_s = signed'({11'd0, green});
    b_s = signed'({11'd0, blue});
    t1 = 19'sd512 * r_s - 19'sd429 * g_s - 19'sd83 * b_s;
    t2 = 19'sd512 * b_s - 19'sd173 * r_s - 19'sd339 * g_s;
    // divide by 4096 rounding toward zero
    q1 = (t1 < 19'sd0) ? ((t1 + 19'sd4095) >>> 12) : (t1 >>> 12);
    q2 = (t2 < 19'sd0) ? ((t2 + 19'sd4095) >>> 12) : (t2 >>> 12);
    res_nxt.luma = y_sum[17:10];
    res_nxt.c1   = q1[7:0] + CHROMA_BIAS;
    res_nxt.c2   = q2[7:0] + CHROMA_BIAS;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ----- design/rycc_merge.sv -----
module rycc_merge #(
  parameter int CW = 10,
  parameter int DEPTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic [CW-1:0]               col,
  input  rycc_pkg::ctrl_t             ctrl,
  input  rycc_pkg::lane_out_t         lane_a,
  input  rycc_pkg::lane_out_t         lane_b,
  output logic                        out_valid,
  output logic [rycc_pkg::PIX_W-1:0]  luma_left,
  output logic [rycc_pkg::PIX_W-1:0]  luma_right,
  output logic                        chroma_valid,
  output logic [rycc_pkg::PIX_W-1:0]  chroma_one,
  output logic [rycc_pkg::PIX_W-1:0]  chroma_two,
  output logic                        frame_end
);
  import rycc_pkg::*;

  logic                     a_valid_r;
  logic [CW-1:0]            a_col_r;
  ctrl_t                    a_ctrl_r;
  logic [PIX_W-1:0]         a_s1, a_s2;

  logic                     b_valid_r;
  ctrl_t                    b_ctrl_r;
  logic [PIX_W-1:0]         b_s1_r, b_s2_r;
  logic [PIX_W-1:0]         b_luma_l_r, b_luma_r_r;
  logic [2*PIX_W-1:0]       rd_r;

  // line store: even-row pair sums per column, {chroma one, chroma two}
  logic [2*PIX_W-1:0]       line_mem [DEPTH];

  assign a_s1 = lane_a.c1 + lane_b.c1;
  assign a_s2 = lane_a.c2 + lane_b.c2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_col_r    <= col;
      a_ctrl_r   <= ctrl;
      b_ctrl_r   <= a_ctrl_r;
      b_s1_r     <= a_s1;
      b_s2_r     <= a_s2;
      b_luma_l_r <= lane_a.luma;
      b_luma_r_r <= lane_b.luma;
    end
  end

  // even rows write, odd rows read the same column one row later
  always_ff @(posedge clk) begin
    if (adv) begin
      if (a_valid_r && !a_ctrl_r.odd_row) begin
        line_mem[a_col_r] <= {a_s1, a_s2};
      end
      rd_r <= line_mem[a_col_r];
    end
  end

  always_comb begin
    out_valid    = b_valid_r;
    luma_left    = b_luma_l_r;
    luma_right   = b_luma_r_r;
    frame_end    = b_ctrl_r.frame_end;
    chroma_valid = b_ctrl_r.odd_row | b_ctrl_r.last_row;
    if (b_ctrl_r.odd_row) begin
      chroma_one = b_s1_r + rd_r[2*PIX_W-1:PIX_W];
      chroma_two = b_s2_r + rd_r[PIX_W-1:0];
    end else if (b_ctrl_r.last_row) begin
      chroma_one = b_s1_r;
      chroma_two = b_s2_r;
    end else begin
      chroma_one = '0;
      chroma_two = '0;
    end
  end

endmodule

// ----- design/rgb_to_ycbcr_420_converter.sv -----
// rgb to ycbcr 4:2:0 stream converter
//
// input channel: in_valid / in_stall with one horizontal rgb pixel pair per
// item, raster in row order. result channel: out_valid / out_stall with the
// luma of both pixels, a chroma pair on odd rows (and on the final row of an
// odd-height frame, holding that row's sum only) and a frame end flag.
// configuration: cfg_wr_en writes cfg_data into register cfg_index
// (0 pairs per row, 1 rows per frame); write only while the block is idle.
//
// two pixel lanes run side by side, then a merge stage sums the pair and
// uses a one-row line store of chroma sums, registered on read.
// a result passes the lane register, then the merge output register.
// throughput: one item per cycle through the lane / merge / output pipeline
// unless out_stall meets out_valid, which holds it all and raises in_stall.
// reset clears the counters, the pipeline valids and loads 320 pairs per row
// and 480 rows; the line store is not cleared, an even row fills it first.
module rgb_to_ycbcr_420_converter #(
  parameter int MAX_PAIRS = 1024,
  parameter int MAX_ROWS  = 2048
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic                             cfg_index,
  input  logic [rycc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [rycc_pkg::PIX_W-1:0]       in_red_a,
  input  logic [rycc_pkg::PIX_W-1:0]       in_green_a,
  input  logic [rycc_pkg::PIX_W-1:0]       in_blue_a,
  input  logic [rycc_pkg::PIX_W-1:0]       in_red_b,
  input  logic [rycc_pkg::PIX_W-1:0]       in_green_b,
  input  logic [rycc_pkg::PIX_W-1:0]       in_blue_b,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [rycc_pkg::PIX_W-1:0]       out_luma_left,
  output logic [rycc_pkg::PIX_W-1:0]       out_luma_right,
  output logic                             out_chroma_valid,
  output logic [rycc_pkg::PIX_W-1:0]       out_chroma_one,
  output logic [rycc_pkg::PIX_W-1:0]       out_chroma_two,
  output logic                             out_frame_end
);
  import rycc_pkg::*;

  localparam int CW  = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int PCW = (CFG_PAIRS_W > CW + 1) ? CFG_PAIRS_W : CW + 1;
  localparam int RCW = (CFG_ROWS_W > RW + 1) ? CFG_ROWS_W : RW + 1;
  localparam logic [PCW-1:0] PAIRS_MAX = PCW'(MAX_PAIRS);
  localparam logic [RCW-1:0] ROWS_MAX  = RCW'(MAX_ROWS);

  logic [CFG_PAIRS_W-1:0] pairs_r;
  logic [CFG_ROWS_W-1:0]  rows_r;
  logic [CW-1:0]          col_r, col_nxt;
  logic [RW-1:0]          row_r, row_nxt;
  logic [PCW-1:0]         pairs_ext, eff_pairs;
  logic [RCW-1:0]         rows_ext, eff_rows;
  logic                   row_end;
  logic                   adv;
  logic                   in_acc;
  ctrl_t                  ctrl;
  lane_out_t              lane_a, lane_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pairs_r <= PAIRS_RESET;
      rows_r  <= ROWS_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_PAIRS_PER_ROW: pairs_r <= cfg_data[CFG_PAIRS_W-1:0];
        REG_FRAME_ROWS:    rows_r  <= cfg_data[CFG_ROWS_W-1:0];
        default:           pairs_r <= pairs_r;
      endcase
    end
  end

  always_comb begin
    pairs_ext = PCW'(pairs_r);
    rows_ext  = RCW'(rows_r);
    // zero acts as one, beyond the maximum acts as the maximum
    if (pairs_ext == '0) begin
      eff_pairs = PCW'(1);
    end else if (pairs_ext > PAIRS_MAX) begin
      eff_pairs = PAIRS_MAX;
    end else begin
      eff_pairs = pairs_ext;
    end
    if (rows_ext == '0) begin
      eff_rows = RCW'(1);
    end else if (rows_ext > ROWS_MAX) begin
      eff_rows = ROWS_MAX;
    end else begin
      eff_rows = rows_ext;
    end
    row_end        = PCW'(col_r) >= (eff_pairs - PCW'(1));
    ctrl.last_row  = RCW'(row_r) >= (eff_rows - RCW'(1));
    ctrl.odd_row   = row_r[0];
    ctrl.frame_end = row_end & ctrl.last_row;
    if (row_end) begin
      col_nxt = '0;
      row_nxt = ctrl.last_row ? '0 : row_r + RW'(1);
    end else begin
      col_nxt = col_r + CW'(1);
      row_nxt = row_r;
    end
  end

  assign in_stall = out_valid & out_stall;
  assign adv      = ~in_stall;
  assign in_acc   = in_valid & adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  rycc_lane u_lane_a (
    .clk   (clk),
    .en    (adv),
    .red   (in_red_a),
    .green (in_green_a),
    .blue  (in_blue_a),
    .res_r (lane_a)
  );

  rycc_lane u_lane_b (
    .clk   (clk),
    .en    (adv),
    .red   (in_red_b),
    .green (in_green_b),
    .blue  (in_blue_b),
    .res_r (lane_b)
  );

  rycc_merge #(
    .CW    (CW),
    .DEPTH (MAX_PAIRS)
  ) u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .in_valid     (in_valid),
    .col          (col_r),
    .ctrl         (ctrl),
    .lane_a       (lane_a),
    .lane_b       (lane_b),
    .out_valid    (out_valid),
    .luma_left    (out_luma_left),
    .luma_right   (out_luma_right),
    .chroma_valid (out_chroma_valid),
    .chroma_one   (out_chroma_one),
    .chroma_two   (out_chroma_two),
    .frame_end    (out_frame_end)
  );

endmodule
